// ----- sv/srei_pkg.sv -----
package srei_pkg;

    localparam int COORD_W = 16;
    localparam int DIM_W   = COORD_W - 1;
    // coordinate differences against the far edges need two bits of growth
    localparam int DIF_W   = COORD_W + 2;
    localparam int PROD_W  = 2 * DIF_W;
    localparam int NUM_W   = PROD_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_x0;
        logic signed [COORD_W-1:0] seg_y0;
        logic signed [COORD_W-1:0] seg_x1;
        logic signed [COORD_W-1:0] seg_y1;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic        [DIM_W-1:0]   rect_w;
        logic        [DIM_W-1:0]   rect_h;
    } t_seg_in;

    typedef struct packed {
        logic hit;
        logic hit_left;
        logic hit_right;
        logic hit_top;
        logic hit_bottom;
    } t_seg_out;

    // segment deltas and start point offsets from the rectangle edges
    typedef struct packed {
        logic signed [DIF_W-1:0] dx;
        logic signed [DIF_W-1:0] dy;
        logic signed [DIF_W-1:0] ax_l;
        logic signed [DIF_W-1:0] ax_r;
        logic signed [DIF_W-1:0] ay_t;
        logic signed [DIF_W-1:0] ay_b;
        logic signed [DIF_W-1:0] w;
        logic signed [DIF_W-1:0] h;
    } t_delta;

    typedef struct packed {
        logic signed [PROD_W-1:0] h_dx;
        logic signed [PROD_W-1:0] w_dy;
        logic signed [PROD_W-1:0] h_axl;
        logic signed [PROD_W-1:0] h_axr;
        logic signed [PROD_W-1:0] w_ayt;
        logic signed [PROD_W-1:0] w_ayb;
        logic signed [PROD_W-1:0] dx_ayt;
        logic signed [PROD_W-1:0] dx_ayb;
        logic signed [PROD_W-1:0] dy_axl;
        logic signed [PROD_W-1:0] dy_axr;
    } t_prod;

    typedef struct packed {
        logic num_en;
        logic flag_en;
    } t_test_en;

endpackage

// ----- sv/srei_delta.sv -----
module srei_delta
    import srei_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_seg_in i_data,
    output t_delta o_delta
);

    t_delta r_delta;
    t_delta n_delta;
    logic signed [DIF_W-1:0] x0;
    logic signed [DIF_W-1:0] y0;
    logic signed [DIF_W-1:0] rx;
    logic signed [DIF_W-1:0] ry;

    always_comb begin
        x0 = DIF_W'(i_data.seg_x0);
        y0 = DIF_W'(i_data.seg_y0);
        rx = DIF_W'(i_data.rect_x);
        ry = DIF_W'(i_data.rect_y);
        n_delta.w    = $signed({{(DIF_W-DIM_W){1'b0}}, i_data.rect_w});
        n_delta.h    = $signed({{(DIF_W-DIM_W){1'b0}}, i_data.rect_h});
        n_delta.dx   = DIF_W'(i_data.seg_x1) - x0;
        n_delta.dy   = DIF_W'(i_data.seg_y1) - y0;
        n_delta.ax_l = x0 - rx;
        n_delta.ay_t = y0 - ry;
        // far edges sit at full precision, no wrap
        n_delta.ax_r = x0 - rx - n_delta.w;
        n_delta.ay_b = y0 - ry - n_delta.h;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

// ----- sv/srei_prod.sv -----
module srei_prod
    import srei_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_delta i_delta,
    output t_prod  o_prod
);

    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod.h_dx   = PROD_W'(i_delta.h)  * PROD_W'(i_delta.dx);
        n_prod.w_dy   = PROD_W'(i_delta.w)  * PROD_W'(i_delta.dy);
        n_prod.h_axl  = PROD_W'(i_delta.h)  * PROD_W'(i_delta.ax_l);
        n_prod.h_axr  = PROD_W'(i_delta.h)  * PROD_W'(i_delta.ax_r);
        n_prod.w_ayt  = PROD_W'(i_delta.w)  * PROD_W'(i_delta.ay_t);
        n_prod.w_ayb  = PROD_W'(i_delta.w)  * PROD_W'(i_delta.ay_b);
        n_prod.dx_ayt = PROD_W'(i_delta.dx) * PROD_W'(i_delta.ay_t);
        n_prod.dx_ayb = PROD_W'(i_delta.dx) * PROD_W'(i_delta.ay_b);
        n_prod.dy_axl = PROD_W'(i_delta.dy) * PROD_W'(i_delta.ax_l);
        n_prod.dy_axr = PROD_W'(i_delta.dy) * PROD_W'(i_delta.ax_r);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/srei_test.sv -----
module srei_test
    import srei_pkg::*;
(
    input  logic     i_clk,
    input  t_test_en i_en,
    input  t_prod    i_prod,
    output t_seg_out o_res
);

    // edge order: left, right, top, bottom
    logic signed [NUM_W-1:0] r_den_lr;
    logic signed [NUM_W-1:0] r_den_tb;
    logic signed [NUM_W-1:0] r_na [4];
    logic signed [NUM_W-1:0] r_nb [4];
    logic signed [NUM_W-1:0] n_den_lr;
    logic signed [NUM_W-1:0] n_den_tb;
    logic signed [NUM_W-1:0] n_na [4];
    logic signed [NUM_W-1:0] n_nb [4];
    logic [3:0] edge_hit;
    t_seg_out   r_res;
    t_seg_out   n_res;

    // num/den within the closed unit interval, zero den never hits
    function automatic logic in_unit(input logic signed [NUM_W-1:0] num,
                                     input logic signed [NUM_W-1:0] den);
        logic res;
        if (den > 0) begin
            res = (num >= 0) && (num <= den);
        end else if (den < 0) begin
            res = (num <= 0) && (num >= den);
        end else begin
            res = 1'b0;
        end
        return res;
    endfunction

    always_comb begin
        n_den_lr = NUM_W'(i_prod.h_dx);
        n_den_tb = -NUM_W'(i_prod.w_dy);
        n_na[0]  = -NUM_W'(i_prod.h_axl);
        n_na[1]  = -NUM_W'(i_prod.h_axr);
        n_na[2]  = NUM_W'(i_prod.w_ayt);
        n_na[3]  = NUM_W'(i_prod.w_ayb);
        n_nb[0]  = NUM_W'(i_prod.dx_ayt) - NUM_W'(i_prod.dy_axl);
        n_nb[1]  = NUM_W'(i_prod.dx_ayt) - NUM_W'(i_prod.dy_axr);
        n_nb[2]  = NUM_W'(i_prod.dx_ayt) - NUM_W'(i_prod.dy_axl);
        n_nb[3]  = NUM_W'(i_prod.dx_ayb) - NUM_W'(i_prod.dy_axl);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.num_en) begin
            r_den_lr <= n_den_lr;
            r_den_tb <= n_den_tb;
            r_na     <= n_na;
            r_nb     <= n_nb;
        end
    end

    always_comb begin
        edge_hit[0] = in_unit(r_na[0], r_den_lr) && in_unit(r_nb[0], r_den_lr);
        edge_hit[1] = in_unit(r_na[1], r_den_lr) && in_unit(r_nb[1], r_den_lr);
        edge_hit[2] = in_unit(r_na[2], r_den_tb) && in_unit(r_nb[2], r_den_tb);
        edge_hit[3] = in_unit(r_na[3], r_den_tb) && in_unit(r_nb[3], r_den_tb);
        n_res.hit_left   = edge_hit[0];
        n_res.hit_right  = edge_hit[1];
        n_res.hit_top    = edge_hit[2];
        n_res.hit_bottom = edge_hit[3];
        n_res.hit        = |edge_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.flag_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- sv/segment_rect_edge_intersect_unit.sv -----
// an accepted word passes four register stages before its result word is on the output
// throughput: one word per cycle while the output does not stall, through the four register stages
// (deltas, products, numerators, edge flags); bubbles close up under stall
// reset clears the stage valid bits only; data registers are not reset
module segment_rect_edge_intersect_unit
    import srei_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_seg_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_seg_out o_data
);

    logic [3:0] r_v;
    logic [3:0] n_v;
    logic [3:0] en;
    t_delta     delta;
    t_prod      prod;
    t_test_en   test_en;

    // a stage loads when it is empty or the one after it moves
    always_comb begin
        en[3] = !r_v[3] || !i_stall;
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
        n_v[0] = en[0] ? i_valid : r_v[0];
        n_v[1] = en[1] ? r_v[0]  : r_v[1];
        n_v[2] = en[2] ? r_v[1]  : r_v[2];
        n_v[3] = en[3] ? r_v[2]  : r_v[3];
        test_en.num_en  = en[2];
        test_en.flag_en = en[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    srei_delta u_delta (
        .i_clk   (i_clk),
        .i_en    (en[0]),
        .i_data  (i_data),
        .o_delta (delta)
    );

    srei_prod u_prod (
        .i_clk   (i_clk),
        .i_en    (en[1]),
        .i_delta (delta),
        .o_prod  (prod)
    );

    srei_test u_test (
        .i_clk  (i_clk),
        .i_en   (test_en),
        .i_prod (prod),
        .o_res  (o_data)
    );

    assign o_stall = !en[0];
    assign o_valid = r_v[3];

endmodule

// ----- tb/tb.sv -----
module tb;
    import srei_pkg::*;

    localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int C_MIN = -C_MAX - 1;
    localparam int D_MAX = (1 << DIM_W) - 1;
    localparam int LONG_HOLD = 300;

    // directed row: input word, whether the result is written out, and that result
    typedef struct packed {
        t_seg_in  word;
        logic     typed;
        t_seg_out want;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_seg_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_seg_out o_data;

    t_seg_out edge_hit_q [$];
    t_seg_out offered_hits;
    t_seg_out oldest_hits;
    t_dir_row dir_tab [$];
    int       n_words_in;
    int       n_words_out;
    int       n_bad;
    bit       idle_on;
    bit       sink_hold_req;

    segment_rect_edge_intersect_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // exact test of num/den against the closed unit interval
    function automatic bit ratio_in_unit(input longint num, input longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        if (den < 0)
            return num <= 0 && num >= den;
        return 1'b0;
    endfunction

    // segment a-b against edge c-e
    function automatic bit edge_crossed(input longint ax, input longint ay,
                                        input longint bx, input longint by,
                                        input longint cx, input longint cy,
                                        input longint ex, input longint ey);
        longint den;
        longint num_seg;
        longint num_edge;
        den      = (ey - cy) * (bx - ax) - (ex - cx) * (by - ay);
        num_seg  = (ex - cx) * (ay - cy) - (ey - cy) * (ax - cx);
        num_edge = (bx - ax) * (ay - cy) - (by - ay) * (ax - cx);
        return ratio_in_unit(num_seg, den) && ratio_in_unit(num_edge, den);
    endfunction

    function automatic t_seg_out predict_edge_hits(input t_seg_in w);
        longint x0, y0, x1, y1, lx, ty, rx, by;
        t_seg_out r;
        x0 = longint'(w.seg_x0);
        y0 = longint'(w.seg_y0);
        x1 = longint'(w.seg_x1);
        y1 = longint'(w.seg_y1);
        lx = longint'(w.rect_x);
        ty = longint'(w.rect_y);
        // far edges keep full precision, no wrap
        rx = lx + longint'(w.rect_w);
        by = ty + longint'(w.rect_h);
        r.hit_left   = edge_crossed(x0, y0, x1, y1, lx, ty, lx, by);
        r.hit_right  = edge_crossed(x0, y0, x1, y1, rx, ty, rx, by);
        r.hit_top    = edge_crossed(x0, y0, x1, y1, lx, ty, rx, ty);
        r.hit_bottom = edge_crossed(x0, y0, x1, y1, lx, by, rx, by);
        r.hit        = r.hit_left | r.hit_right | r.hit_top | r.hit_bottom;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
        if (v > C_MAX)
            v = C_MAX;
        if (v < C_MIN)
            v = C_MIN;
        return COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 6))
            0: return clamp_coord(C_MIN);
            1: return clamp_coord(C_MIN + 1);
            2: return clamp_coord(-1);
            3: return clamp_coord(0);
            4: return clamp_coord(1);
            5: return clamp_coord(C_MAX - 1);
            default: return clamp_coord(C_MAX);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] extreme_dim();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'(D_MAX - 1);
            default: return DIM_W'(D_MAX);
        endcase
    endfunction

    function automatic int near_offset(input int span);
        return int'($urandom_range(0, 4 * span)) - 2 * span;
    endfunction

    function automatic t_seg_in random_word();
        t_seg_in w;
        int span;
        int cx;
        int cy;
        case ($urandom_range(0, 9))
            0, 1: begin
                w.seg_x0 = COORD_W'($urandom);
                w.seg_y0 = COORD_W'($urandom);
                w.seg_x1 = COORD_W'($urandom);
                w.seg_y1 = COORD_W'($urandom);
                w.rect_x = COORD_W'($urandom);
                w.rect_y = COORD_W'($urandom);
                w.rect_w = DIM_W'($urandom);
                w.rect_h = DIM_W'($urandom);
            end
            2: begin
                w.seg_x0 = extreme_coord();
                w.seg_y0 = extreme_coord();
                w.seg_x1 = extreme_coord();
                w.seg_y1 = extreme_coord();
                w.rect_x = extreme_coord();
                w.rect_y = extreme_coord();
                w.rect_w = extreme_dim();
                w.rect_h = extreme_dim();
            end
            default: begin
                // segment placed around the rectangle so edges really get crossed
                case ($urandom_range(0, 3))
                    0: span = 8;
                    1: span = 100;
                    2: span = 3000;
                    default: span = 16000;
                endcase
                cx = int'($urandom_range(0, 2 * C_MAX)) - C_MAX;
                cy = int'($urandom_range(0, 2 * C_MAX)) - C_MAX;
                w.rect_x = clamp_coord(cx - int'($urandom_range(0, span)));
                w.rect_y = clamp_coord(cy - int'($urandom_range(0, span)));
                w.rect_w = DIM_W'($urandom_range(0, 2 * span));
                w.rect_h = DIM_W'($urandom_range(0, 2 * span));
                w.seg_x0 = clamp_coord(cx + near_offset(span));
                w.seg_y0 = clamp_coord(cy + near_offset(span));
                w.seg_x1 = clamp_coord(cx + near_offset(span));
                w.seg_y1 = clamp_coord(cy + near_offset(span));
                case ($urandom_range(0, 7))
                    0: w.seg_y1 = w.seg_y0;
                    1: w.seg_x1 = w.seg_x0;
                    2: begin
                        w.seg_x1 = w.seg_x0;
                        w.seg_y1 = w.seg_y0;
                    end
                    3: w.seg_x0 = w.rect_x;
                    4: w.rect_w = '0;
                    5: w.rect_h = '0;
                    default: ;
                endcase
            end
        endcase
        return w;
    endfunction

    // want bits are hit, left, right, top, bottom
    function automatic t_dir_row dir_row(input int x0, input int y0, input int x1,
                                         input int y1, input int rx, input int ry,
                                         input int rw, input int rh, input bit typed,
                                         input logic [4:0] want);
        t_dir_row r;
        r.word.seg_x0 = clamp_coord(x0);
        r.word.seg_y0 = clamp_coord(y0);
        r.word.seg_x1 = clamp_coord(x1);
        r.word.seg_y1 = clamp_coord(y1);
        r.word.rect_x = clamp_coord(rx);
        r.word.rect_y = clamp_coord(ry);
        r.word.rect_w = DIM_W'(rw);
        r.word.rect_h = DIM_W'(rh);
        r.typed       = typed;
        r.want        = want;
        return r;
    endfunction

    task automatic send_word(input t_seg_in w, input t_seg_out hits);
        int gap;
        int target;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data       <= w;
        offered_hits <= hits;
        target = n_words_in + 1;
        do @(negedge i_clk); while (n_words_in < target);
    endtask

    task automatic send_random(input int n);
        t_seg_in w;
        for (int k = 0; k < n; k++) begin
            w = random_word();
            send_word(w, predict_edge_hits(w));
        end
    endtask

    task automatic note_mismatch(input string msg);
        n_bad++;
        if (n_bad <= 10)
            $display("mismatch: %s", msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result check first, then record the accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_words_out++;
                if (edge_hit_q.size() == 0) begin
                    note_mismatch($sformatf("result word %0d with nothing outstanding: %b",
                                            n_words_out, o_data));
                end else begin
                    oldest_hits = edge_hit_q.pop_front();
                    if (o_data.hit !== oldest_hits.hit
                            || o_data.hit_left !== oldest_hits.hit_left
                            || o_data.hit_right !== oldest_hits.hit_right
                            || o_data.hit_top !== oldest_hits.hit_top
                            || o_data.hit_bottom !== oldest_hits.hit_bottom)
                        note_mismatch($sformatf(
                            "word %0d (hit,left,right,top,bottom) expected %b actual %b",
                            n_words_out, oldest_hits, o_data));
                end
            end
            if (i_valid && !o_stall) begin
                edge_hit_q.push_back(offered_hits);
                n_words_in++;
            end
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin : sink_ctl
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                sink_hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_dir_row row;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        offered_hits  = '0;
        n_words_in    = 0;
        n_words_out   = 0;
        n_bad         = 0;
        idle_on       = 1'b1;
        sink_hold_req = 1'b0;

        dir_tab.push_back(dir_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 5'b00000));
        // zero-length segment sitting on the left edge
        dir_tab.push_back(dir_row(0, 5, 0, 5, 0, 0, 10, 10, 1, 5'b00000));
        dir_tab.push_back(dir_row(-10, 5, 20, 5, 0, 0, 10, 10, 1, 5'b11100));
        dir_tab.push_back(dir_row(5, -10, 5, 20, 0, 0, 10, 10, 1, 5'b10011));
        // through both corners
        dir_tab.push_back(dir_row(-5, -5, 15, 15, 0, 0, 10, 10, 1, 5'b11111));
        dir_tab.push_back(dir_row(2, 2, 8, 8, 0, 0, 10, 10, 1, 5'b00000));
        // endpoint just touching the left edge
        dir_tab.push_back(dir_row(-5, 5, 0, 5, 0, 0, 10, 10, 1, 5'b11000));
        dir_tab.push_back(dir_row(100, 100, 200, 200, 0, 0, 10, 10, 1, 5'b00000));
        // collinear with the left edge
        dir_tab.push_back(dir_row(0, -5, 0, 20, 0, 0, 10, 10, 0, '0));
        dir_tab.push_back(dir_row(-5, 5, 5, 5, 0, 0, 0, 10, 0, '0));
        dir_tab.push_back(dir_row(5, -5, 5, 5, 0, 0, 10, 0, 0, '0));
        dir_tab.push_back(dir_row(20, 5, -10, 5, 0, 0, 10, 10, 0, '0));
        // right edge beyond the coordinate range
        dir_tab.push_back(dir_row(C_MAX, 0, C_MIN, 0, C_MAX, -100, D_MAX, 200, 0, '0));
        dir_tab.push_back(dir_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, D_MAX, D_MAX,
                                  0, '0));
        dir_tab.push_back(dir_row(C_MIN, C_MAX, C_MAX, C_MIN, -1000, -1000, 2000, 2000,
                                  0, '0));
        dir_tab.push_back(dir_row(-1, -1, -1, -1, -1, -1, D_MAX, D_MAX, 0, '0));
        dir_tab.push_back(dir_row(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, D_MAX, D_MAX,
                                  0, '0));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) begin
            row = dir_tab[k];
            send_word(row.word, row.typed ? row.want : predict_edge_hits(row.word));
        end

        send_random(700);

        // long hold on the result side while words keep coming
        sink_hold_req = 1'b1;
        send_random(60);

        // sender waits for the pipe to drain completely
        i_valid <= 1'b0;
        while (edge_hit_q.size() != 0) @(negedge i_clk);

        send_random(850);

        // last stretch back to back
        idle_on = 1'b0;
        send_random(280);
        i_valid <= 1'b0;

        while (edge_hit_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (n_bad == 0 && edge_hit_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
